>>> sv/vector3_normalizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector normalizer
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZER_UNIT_ASSERT_SVH
`define VECTOR3_NORMALIZER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VNU_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vector normalizer check failed");

// antecedent implies consequent in the next cycle
`define VNU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vector normalizer check failed");

`endif

>>> sv/vnu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnu_pkg
// Shared types and pipeline depths of the vector normalizer.
// ----------------------------------------------------------------------------
package vnu_pkg;

   localparam int NUM_LANES  = 3;
   localparam int FRONT_LAT  = 3;
   localparam int DIV_STEPS  = 63;
   localparam int SQRT_STEPS = 32;
   localparam int LANE_LAT   = DIV_STEPS + SQRT_STEPS + 2;
   localparam int PIPE_DEPTH = FRONT_LAT + LANE_LAT;

   localparam logic [31:0] Q_ONE = 32'h4000_0000;

   typedef logic signed [31:0] comp_type;
   typedef logic [31:0]        mag_type;
   typedef logic [62:0]        sq_type;
   typedef logic [63:0]        sum_type;

   // per-stage control carried alongside the datapath
   typedef struct packed {
      logic valid;
      logic zero_length;
   } ctrl_type;

   // one finished result
   typedef struct packed {
      logic     zero_length;
      comp_type unit_x;
      comp_type unit_y;
      comp_type unit_z;
   } rsp_type;

endpackage

>>> sv/vnu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnu_front
// Magnitudes, squares and the exact sum of squares, three register stages.
// ----------------------------------------------------------------------------
module vnu_front import vnu_pkg::*; (
   input  logic                           clock,
   input  logic                           en,
   input  comp_type [NUM_LANES-1:0]       comp,
   output sq_type   [NUM_LANES-1:0]       sq_out,
   output sum_type                        sum_out,
   output logic     [NUM_LANES-1:0]       neg_out
);

   mag_type [NUM_LANES-1:0] mag_ff, mag_in;
   logic    [NUM_LANES-1:0] neg1_ff, neg2_ff, neg3_ff;
   sq_type  [NUM_LANES-1:0] sq2_ff, sq2_in, sq3_ff;
   logic    [NUM_LANES-1:0][63:0] prod;
   sum_type sum_ff, sum_in;

   // magnitude; the most negative value maps to 2^31
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         mag_in[i] = comp[i][31] ? (~mag_type'(comp[i]) + 32'd1) : mag_type'(comp[i]);
         prod[i]   = mag_ff[i] * mag_ff[i];
         sq2_in[i] = prod[i][62:0];
      end
   end

   assign sum_in = 64'(sq2_ff[0]) + 64'(sq2_ff[1]) + 64'(sq2_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg1_ff <= {comp[2][31], comp[1][31], comp[0][31]};
         sq2_ff  <= sq2_in;
         neg2_ff <= neg1_ff;
         sq3_ff  <= sq2_ff;
         sum_ff  <= sum_in;
         neg3_ff <= neg2_ff;
      end
   end

   assign sq_out  = sq3_ff;
   assign sum_out = sum_ff;
   assign neg_out = neg3_ff;

endmodule

>>> sv/vnu_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnu_lane
// One component: T = floor(c^2 * 2^62 / S) by a radix-2 divider pipeline,
// r = isqrt(T) by a digit pipeline, then q = (r + 1) / 2, clamp, sign.
// ----------------------------------------------------------------------------
module vnu_lane import vnu_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  sq_type   c2,
   input  sum_type  sum,
   input  logic     neg,
   output comp_type unit
);

   // divider stage registers, index 0 is the lane input register
   logic [63:0] drem_ff [0:DIV_STEPS-1];
   sum_type     dsum_ff [0:DIV_STEPS-1];
   logic [62:0] dquo_ff [1:DIV_STEPS];
   logic        dneg_ff [0:DIV_STEPS];
   logic        bit0_ff;

   // square root stage registers
   logic [34:0] srem_ff [1:SQRT_STEPS-1];
   logic [63:0] st_ff   [1:SQRT_STEPS-1];
   logic [31:0] sroot_ff[1:SQRT_STEPS];
   logic        sneg_ff [1:SQRT_STEPS];

   logic [32:0] q_inc;
   logic [31:0] q_mag;
   comp_type    unit_ff, unit_in;

   // lane input: dividend c2 * 2^62, first remainder c2 >> 1 (below S)
   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff[0] <= {2'b00, c2[62:1]};
         bit0_ff    <= c2[0];
         dsum_ff[0] <= sum;
         dneg_ff[0] <= neg;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [64:0] cat, diff;
      logic [62:0] quo_prev;
      logic        in_bit, ge;

      if (k == 1) begin : g_first
         assign quo_prev = '0;
         assign in_bit   = bit0_ff;
      end else begin : g_next
         assign quo_prev = dquo_ff[k-1];
         assign in_bit   = 1'b0;
      end

      assign cat  = {drem_ff[k-1], in_bit};
      assign ge   = cat >= {1'b0, dsum_ff[k-1]};
      assign diff = cat - {1'b0, dsum_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            dquo_ff[k] <= {quo_prev[61:0], ge};
            dneg_ff[k] <= dneg_ff[k-1];
         end
      end

      if (k < DIV_STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[k] <= ge ? diff[63:0] : cat[63:0];
               dsum_ff[k] <= dsum_ff[k-1];
            end
         end
      end
   end

   // integer square root, one root bit per stage
   for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
      logic [34:0] rem_prev, r4, trial, sub;
      logic [63:0] t_prev;
      logic [31:0] root_prev;
      logic        neg_prev, ge;

      if (j == 1) begin : g_first
         assign rem_prev  = '0;
         assign t_prev    = {1'b0, dquo_ff[DIV_STEPS]};
         assign root_prev = '0;
         assign neg_prev  = dneg_ff[DIV_STEPS];
      end else begin : g_next
         assign rem_prev  = srem_ff[j-1];
         assign t_prev    = st_ff[j-1];
         assign root_prev = sroot_ff[j-1];
         assign neg_prev  = sneg_ff[j-1];
      end

      assign r4    = {rem_prev[32:0], t_prev[63:62]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = r4 >= trial;
      assign sub   = r4 - trial;

      always_ff @(posedge clock) begin
         if (en) begin
            sroot_ff[j] <= {root_prev[30:0], ge};
            sneg_ff[j]  <= neg_prev;
         end
      end

      if (j < SQRT_STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               srem_ff[j] <= ge ? sub : r4;
               st_ff[j]   <= {t_prev[61:0], 2'b00};
            end
         end
      end
   end

   // largest odd d <= r gives q = (r + 1) / 2; clamp to one, apply sign
   always_comb begin
      q_inc   = {1'b0, sroot_ff[SQRT_STEPS]} + 33'd1;
      q_mag   = (q_inc[32:1] > Q_ONE) ? Q_ONE : q_inc[32:1];
      unit_in = sneg_ff[SQRT_STEPS] ? comp_type'(~q_mag + 32'd1) : comp_type'(q_mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
      end
   end

   assign unit = unit_ff;

endmodule

>>> sv/vnu_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnu_merge
// Joins the lane results and the zero flag into one response and holds it
// in a two-entry output queue; room for a push is known from registers only.
// ----------------------------------------------------------------------------
module vnu_merge import vnu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_type                 ctrl_in,
   input  comp_type [NUM_LANES-1:0] unit_in,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output comp_type                 rsp_unit_x,
   output comp_type                 rsp_unit_y,
   output comp_type                 rsp_unit_z,
   output logic                     rsp_zero_length
);

   rsp_type     ent_ff [0:1];
   rsp_type     ent_in;
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign room      = count_ff != 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign push      = ctrl_in.valid && room;
   assign pop       = rsp_valid && rsp_ready;

   // zero vector forces zero components
   always_comb begin
      ent_in.zero_length = ctrl_in.zero_length;
      ent_in.unit_x      = ctrl_in.zero_length ? '0 : unit_in[0];
      ent_in.unit_y      = ctrl_in.zero_length ? '0 : unit_in[1];
      ent_in.unit_z      = ctrl_in.zero_length ? '0 : unit_in[2];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
   end

   assign rsp_unit_x      = ent_ff[rd_ptr_ff].unit_x;
   assign rsp_unit_y      = ent_ff[rd_ptr_ff].unit_y;
   assign rsp_unit_z      = ent_ff[rd_ptr_ff].unit_z;
   assign rsp_zero_length = ent_ff[rd_ptr_ff].zero_length;

endmodule

>>> sv/vector3_normalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalizer_unit
// Scales a signed 3-vector to unit length, Q1.30 outputs, round to nearest.
//
//   channel | ports              | direction | contents
//   req     | req_valid/ready    | in        | comp_x, comp_y, comp_z
//   rsp     | rsp_valid/ready    | out       | unit_x/y/z, zero_length
//
// One request per cycle. From acceptance to rsp_valid a request passes through
// 3 front stages, 63 divider stages, 32 square root stages, 2 lane registers
// and the output queue. A two-entry output queue takes requests while results
// wait; when it is full the whole pipeline holds. Reset clears control state only.
// ----------------------------------------------------------------------------
module vector3_normalizer_unit import vnu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  comp_type req_comp_x,
   input  comp_type req_comp_y,
   input  comp_type req_comp_z,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output comp_type rsp_unit_x,
   output comp_type rsp_unit_y,
   output comp_type rsp_unit_z,
   output logic     rsp_zero_length
);

   logic                     en;
   ctrl_type                 ctrl_ff [1:PIPE_DEPTH];
   ctrl_type                 ctrl_in;
   comp_type [NUM_LANES-1:0] comp;
   sq_type   [NUM_LANES-1:0] sq;
   sum_type                  sum;
   logic     [NUM_LANES-1:0] neg;
   comp_type [NUM_LANES-1:0] unit;

   assign req_ready = en;
   assign comp      = {req_comp_z, req_comp_y, req_comp_x};

   // control pipeline alongside the datapath
   always_comb begin
      ctrl_in.valid       = req_valid && req_ready;
      ctrl_in.zero_length = (req_comp_x == '0) && (req_comp_y == '0) && (req_comp_z == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= PIPE_DEPTH; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else if (en) begin
         ctrl_ff[1] <= ctrl_in;
         for (int i = 2; i <= PIPE_DEPTH; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   vnu_front u_front (
      .clock   (clock),
      .en      (en),
      .comp    (comp),
      .sq_out  (sq),
      .sum_out (sum),
      .neg_out (neg)
   );

   // one lane per component
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      vnu_lane u_lane (
         .clock (clock),
         .en    (en),
         .c2    (sq[l]),
         .sum   (sum),
         .neg   (neg[l]),
         .unit  (unit[l])
      );
   end

   vnu_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .ctrl_in         (ctrl_ff[PIPE_DEPTH]),
      .unit_in         (unit),
      .room            (en),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_unit_x      (rsp_unit_x),
      .rsp_unit_y      (rsp_unit_y),
      .rsp_unit_z      (rsp_unit_z),
      .rsp_zero_length (rsp_zero_length)
   );

   // checks
   `include "vector3_normalizer_unit_assert.svh"

   `VNU_ASSERT_IMPLY(a_zero_out, rsp_valid && rsp_zero_length, (rsp_unit_x == '0) && (rsp_unit_y == '0) && (rsp_unit_z == '0))
   `VNU_ASSERT_IMPLY(a_nonzero_out, rsp_valid && !rsp_zero_length, (rsp_unit_x != '0) || (rsp_unit_y != '0) || (rsp_unit_z != '0))
   `VNU_ASSERT_IMPLY(a_range_x, rsp_valid, (rsp_unit_x <= $signed(Q_ONE)) && (rsp_unit_x >= -$signed(Q_ONE)))
   `VNU_ASSERT_NEXT(a_hold_full, rsp_valid && !rsp_ready && !req_ready, !req_ready)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector3_normalizer_unit. Directed vectors (zero,
// axis-aligned, most negative, extremes) then random vectors with random
// gaps on both channels; every response is compared against an exact
// round-to-nearest Q1.30 unit-vector predictor.
// ----------------------------------------------------------------------------
module tb;
   import vnu_pkg::*;

   localparam int LATENCY   = 101;
   localparam int N_RANDOM  = 1250;
   localparam int IDLE_LIMIT = 20000;

   // expected response
   typedef struct {
      logic [31:0] ux;
      logic [31:0] uy;
      logic [31:0] uz;
      logic        zl;
   } unit_vec_t;

   // --------------------------------------------------------------------
   // unit-vector predictor and response store
   // --------------------------------------------------------------------
   class unit_scoreboard;
      unit_vec_t pending[$];
      int mismatches;
      int checked;

      // rounded Q1.30 magnitude of m / sqrt(s)
      static function logic [31:0] scaled_mag(logic [63:0] m, logic [63:0] s);
         logic [127:0] rhs;
         logic [127:0] lhs;
         logic [63:0]  q;
         logic [63:0]  t;
         logic [63:0]  d;
         rhs = {64'd0, m * m} << 62;
         q = 0;
         for (int b = 30; b >= 0; b--) begin
            t = q | (64'd1 << b);
            d = 2 * t - 1;
            lhs = {64'd0, d * d} * {64'd0, s};
            if (lhs <= rhs) q = t;
         end
         if (q > 64'(Q_ONE)) q = 64'(Q_ONE);
         return q[31:0];
      endfunction

      static function logic [31:0] signed_unit(logic [31:0] c, logic [63:0] s);
         logic [63:0] m;
         logic [31:0] q;
         m = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
         q = scaled_mag(m, s);
         return c[31] ? -q : q;
      endfunction

      function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
         unit_vec_t e;
         logic [63:0] mx, my, mz, s;
         mx = x[31] ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
         my = y[31] ? (64'h1_0000_0000 - {32'd0, y}) : {32'd0, y};
         mz = z[31] ? (64'h1_0000_0000 - {32'd0, z}) : {32'd0, z};
         s = mx * mx + my * my + mz * mz;
         if (s == 0) begin
            e = '{32'd0, 32'd0, 32'd0, 1'b1};
         end else begin
            e.ux = signed_unit(x, s);
            e.uy = signed_unit(y, s);
            e.uz = signed_unit(z, s);
            e.zl = 1'b0;
         end
         pending.push_back(e);
      endfunction

      function void check_response(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic zl);
         unit_vec_t e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h %h %h %b", x, y, z, zl);
            return;
         end
         e = pending.pop_front();
         if (x !== e.ux || y !== e.uy || z !== e.uz || zl !== e.zl) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                        e.ux, e.uy, e.uz, e.zl, x, y, z, zl);
         end
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   comp_type req_comp_x;
   comp_type req_comp_y;
   comp_type req_comp_z;
   logic     rsp_valid;
   logic     rsp_ready;
   comp_type rsp_unit_x;
   comp_type rsp_unit_y;
   comp_type rsp_unit_z;
   logic     rsp_zero_length;

   unit_scoreboard sb;
   int  idle_cycles;
   bit  done;
   int  n_sent;
   int  n_zero;

   vector3_normalizer_unit u_top (.*);

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // random gap length, mostly short
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   function automatic logic [31:0] rand_comp();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(0, 20)) - 10);
         4: return $urandom() >> $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   // send one request, waiting for acceptance
   task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_valid  <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      do @(posedge clock); while (!req_ready);
      sb.note_request(x, y, z);
      n_sent++;
      if (x == 0 && y == 0 && z == 0) n_zero++;
      repeat (gap_len()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // response side: random stalls, check on acceptance
   initial begin
      int g;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         g = ($urandom_range(0, 9) < 3) ? gap_len() : 0;
         rsp_ready <= (g == 0);
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_zero_length);
         if (g > 0) begin
            repeat (g - 1) @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT && !done) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("** vector3_normalizer_unit: FAILED **");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      sb = new();
      done = 0;
      n_sent = 0;
      n_zero = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_comp_x = '0;
      req_comp_y = '0;
      req_comp_z = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero vector, axes, extremes, most negative value
      send_vec(0, 0, 0);
      send_vec(1, 0, 0);
      send_vec(0, -1, 0);
      send_vec(0, 0, 32'h7fff_ffff);
      send_vec(32'h8000_0000, 0, 0);
      send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_vec(1, 1, 1);
      send_vec(-1, 1, -1);
      send_vec(3, 4, 0);
      send_vec(1, 2, 2);
      send_vec(32'h8000_0000, 1, 0);
      send_vec(1, 32'h7fff_ffff, -1);
      send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_vec(32'h5555_5555, 32'haaaa_aaaa, 0);
      send_vec(0, 0, 0);

      // hold off until the pipeline drains
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 100 == 0)
            send_vec(0, 0, 0);
         else
            send_vec(rand_comp(), rand_comp(), rand_comp());
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      done = 1;

      $display("covered %0d vectors (%0d zero-length), %0d responses checked",
               n_sent, n_zero, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("** vector3_normalizer_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches,
                  sb.pending.size());
         $display("** vector3_normalizer_unit: FAILED **");
      end
      $finish;
   end

endmodule
